// File: sv/lnwb_pkg.sv
// shared types and constants for the 4-bit character lcd write and busy-poll block
package lnwb_pkg;

	localparam int HOLD_W = 16;
	localparam int STEP_W = 3;

	// pin state: driven flag, enable, read/write, register select, bus latch
	typedef struct packed {
		logic       drv;
		logic       e;
		logic       rw;
		logic       rs;
		logic [3:0] bus;
	} pins_t;

	localparam pins_t PINS_RESET = '{drv: 1'b1, e: 1'b0, rw: 1'b0, rs: 1'b0, bus: 4'h0};

	// request kinds on the input word
	localparam logic REQ_SEND   = 1'b0;
	localparam logic REQ_STATUS = 1'b1;

	// configuration register indexes
	typedef enum logic [0:0] {
		CFG_WRITE_HOLD = 1'b0,
		CFG_POLL_HOLD  = 1'b1
	} cfg_idx_t;

	localparam logic [HOLD_W-1:0] WRITE_HOLD_RESET = 16'd2;
	localparam logic [HOLD_W-1:0] POLL_HOLD_RESET  = 16'd1;

	// protocol phase kept by the front end
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_HIGH = 2'd1,
		PH_LOW  = 2'd2
	} phase_t;

	// work handed from front to back
	typedef enum logic [1:0] {
		K_SEND      = 2'd0,
		K_POLL_NEXT = 2'd1,
		K_POLL_DONE = 2'd2,
		K_ERR       = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] byte_value;
		logic       is_data;
	} cmd_t;

	// last step index of each run
	localparam logic [STEP_W-1:0] SEND_LAST = 3'd6;
	localparam logic [STEP_W-1:0] POLL_LAST = 3'd2;

	// queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// File: sv/lnwb_if.sv
// handshake channels: request input, pin-state results and configuration writes
interface lnwb_in_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] byte_value;
	logic       is_data;
	logic [3:0] sampled_nibble;

	modport source (output valid, req_type, byte_value, is_data, sampled_nibble, input ready);
	modport sink (input valid, req_type, byte_value, is_data, sampled_nibble, output ready);
endinterface

interface lnwb_out_if;
	logic        valid;
	logic        ready;
	logic        rs_pin;
	logic        rw_pin;
	logic        enable_pin;
	logic [3:0]  bus_nibble;
	logic        bus_drive;
	logic [15:0] hold_ticks;
	logic        sample_now;
	logic        transfer_done;
	logic        order_error;
	logic        last;

	modport source (output valid, rs_pin, rw_pin, enable_pin, bus_nibble, bus_drive,
		hold_ticks, sample_now, transfer_done, order_error, last, input ready);
	modport sink (input valid, rs_pin, rw_pin, enable_pin, bus_nibble, bus_drive,
		hold_ticks, sample_now, transfer_done, order_error, last, output ready);
endinterface

interface lnwb_cfg_if;
	logic                valid;
	logic                ready;
	lnwb_pkg::cfg_idx_t  index;
	logic [15:0]         data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: sv/lnwb_front.sv
// front end: accepts words, tracks the poll phase and classifies each word
module lnwb_front (
	input  logic              clk,
	input  logic              arst_n,
	lnwb_in_if.sink           req,
	input  lnwb_pkg::q_stat_t q_stat,
	output logic              push,
	output lnwb_pkg::cmd_t    push_cmd
);

	lnwb_pkg::phase_t phase_q, phase_d;
	logic [3:0]       status_high_q;
	logic             accept;
	logic             is_idle;

	assign req.ready = !q_stat.full;
	assign accept    = req.valid && req.ready;
	assign push      = accept;
	assign is_idle   = (phase_q != lnwb_pkg::PH_HIGH) && (phase_q != lnwb_pkg::PH_LOW);

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			unique case (phase_q)
				lnwb_pkg::PH_HIGH: begin
					if (req.req_type == lnwb_pkg::REQ_STATUS) phase_d = lnwb_pkg::PH_LOW;
				end
				lnwb_pkg::PH_LOW: begin
					if (req.req_type == lnwb_pkg::REQ_STATUS) begin
						phase_d = status_high_q[3] ? lnwb_pkg::PH_HIGH : lnwb_pkg::PH_IDLE;
					end
				end
				default: begin
					if (req.req_type == lnwb_pkg::REQ_SEND) phase_d = lnwb_pkg::PH_HIGH;
				end
			endcase
		end
	end

	// classify the word for the back end
	always_comb begin
		push_cmd.byte_value = req.byte_value;
		push_cmd.is_data    = req.is_data;
		push_cmd.kind       = lnwb_pkg::K_ERR;
		if ((req.req_type == lnwb_pkg::REQ_SEND) == is_idle) begin
			if (req.req_type == lnwb_pkg::REQ_SEND) begin
				push_cmd.kind = lnwb_pkg::K_SEND;
			end else if (phase_q == lnwb_pkg::PH_HIGH || status_high_q[3]) begin
				push_cmd.kind = lnwb_pkg::K_POLL_NEXT;
			end else begin
				push_cmd.kind = lnwb_pkg::K_POLL_DONE;
			end
		end
	end

	// phase and kept high status nibble
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= lnwb_pkg::PH_IDLE;
			status_high_q <= 4'h0;
		end else begin
			phase_q <= phase_d;
			if (accept && phase_q == lnwb_pkg::PH_HIGH && req.req_type == lnwb_pkg::REQ_STATUS) begin
				status_high_q <= req.sampled_nibble;
			end
		end
	end

endmodule

// File: sv/lnwb_queue.sv
// two-entry command queue between front and back
module lnwb_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lnwb_pkg::cmd_t    push_cmd,
	input  logic              pop,
	output lnwb_pkg::cmd_t    head,
	output lnwb_pkg::q_stat_t q_stat
);

	lnwb_pkg::cmd_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign head         = mem_q[rd_ptr_q];
	assign q_stat.full  = (count_q == 2'd2);
	assign q_stat.empty = (count_q == 2'd0);

	// entry storage, cleared so an empty head still decodes to a known kind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_q[0] <= '0;
			mem_q[1] <= '0;
		end else if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// File: sv/lnwb_back.sv
// back end: steps through the pin states of each command and registers the result word
module lnwb_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lnwb_pkg::cmd_t              head,
	input  lnwb_pkg::q_stat_t           q_stat,
	input  logic [lnwb_pkg::HOLD_W-1:0] write_hold,
	input  logic [lnwb_pkg::HOLD_W-1:0] poll_hold,
	output logic                        pop,
	lnwb_out_if.source                  res
);

	lnwb_pkg::pins_t             pin_q, pin_c;
	logic [lnwb_pkg::STEP_W-1:0] step_q;
	logic [lnwb_pkg::HOLD_W-1:0] hold_c;
	logic                        sample_c, done_c, err_c, last_c;
	logic                        advance;

	logic                        valid_q;
	lnwb_pkg::pins_t             rpin_q;
	logic [lnwb_pkg::HOLD_W-1:0] hold_q;
	logic                        sample_q, done_q, err_q, last_q;

	assign advance = !q_stat.empty && (!valid_q || res.ready);
	assign pop     = advance && last_c;

	// pin state and flags for the current step
	always_comb begin
		pin_c    = pin_q;
		hold_c   = poll_hold;
		sample_c = 1'b0;
		done_c   = 1'b0;
		err_c    = 1'b0;
		last_c   = 1'b0;
		unique case (head.kind)
			lnwb_pkg::K_SEND: begin
				hold_c = write_hold;
				case (step_q)
					3'd0: begin
						pin_c.rs  = head.is_data;
						pin_c.rw  = 1'b0;
						pin_c.e   = 1'b0;
						pin_c.drv = 1'b1;
					end
					3'd1: begin
						pin_c.e   = 1'b1;
						pin_c.bus = head.byte_value[7:4];
					end
					3'd2: pin_c.e = 1'b0;
					3'd3: begin
						pin_c.e   = 1'b1;
						pin_c.bus = head.byte_value[3:0];
					end
					3'd4: pin_c.e = 1'b0;
					3'd5: begin
						pin_c.drv = 1'b0;
						pin_c.rs  = 1'b0;
						pin_c.rw  = 1'b1;
						hold_c    = poll_hold;
					end
					default: begin
						pin_c.e  = 1'b1;
						hold_c   = poll_hold;
						sample_c = 1'b1;
						last_c   = 1'b1;
					end
				endcase
			end
			lnwb_pkg::K_POLL_NEXT, lnwb_pkg::K_POLL_DONE: begin
				case (step_q)
					3'd0: ;
					3'd1: pin_c.e = 1'b0;
					default: begin
						last_c = 1'b1;
						if (head.kind == lnwb_pkg::K_POLL_NEXT) begin
							pin_c.e  = 1'b1;
							sample_c = 1'b1;
						end else begin
							pin_c.rw  = 1'b0;
							pin_c.drv = 1'b1;
							hold_c    = '0;
							done_c    = 1'b1;
						end
					end
				endcase
			end
			lnwb_pkg::K_ERR: begin
				hold_c = '0;
				err_c  = 1'b1;
				last_c = 1'b1;
			end
		endcase
	end

	// pin latch and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_q  <= lnwb_pkg::PINS_RESET;
			step_q <= '0;
		end else if (advance) begin
			pin_q  <= pin_c;
			step_q <= last_c ? '0 : step_q + 3'd1;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rpin_q   <= pin_c;
			hold_q   <= hold_c;
			sample_q <= sample_c;
			done_q   <= done_c;
			err_q    <= err_c;
			last_q   <= last_c;
		end
	end

	assign res.valid         = valid_q;
	assign res.rs_pin        = rpin_q.rs;
	assign res.rw_pin        = rpin_q.rw;
	assign res.enable_pin    = rpin_q.e;
	assign res.bus_nibble    = rpin_q.bus;
	assign res.bus_drive     = rpin_q.drv;
	assign res.hold_ticks    = hold_q;
	assign res.sample_now    = sample_q;
	assign res.transfer_done = done_q;
	assign res.order_error   = err_q;
	assign res.last          = last_q;

	// step counter never passes the longest run
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= lnwb_pkg::SEND_LAST)
		else $error("step counter out of range");

	// retiring a command presents its final word next cycle
	a_pop_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (res.valid && res.last))
		else $error("command retired without a final word");

	// done word always shows write mode with the bus driven
	a_done_pins: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.transfer_done) |-> (!res.rw_pin && res.bus_drive && res.last))
		else $error("done word without write mode restored");

endmodule

// File: sv/lcd_nibble_write_busy_poll.sv
// top level of the 4-bit character lcd byte write with busy-flag polling
//
// req carries send words (byte plus command/data flag) and status words (the
// nibble sampled from the data pins while enable was high). Each word becomes
// a run of pin-state words on res, the final one marked last: seven for a send,
// three for a status nibble, one for a word that arrives in the wrong phase
// (flagged order_error, pins shown unchanged, nothing else changes).
// cfg writes the two hold counts (index 0 write hold, 1 poll hold); cfg is
// always ready. The user must write cfg only while the block is idle; the
// block itself does not enforce this. A front end classifies each word
// against the poll phase and queues it in a two-entry queue; the back end
// emits one pin-state word per cycle from the queue head while the queue is
// not empty and res is not stalled. Each word passes a queue entry and then
// the output register; the back end step sequencer sets the run length.
// req stays ready while the queue has room, also while res is stalled.
// Reset puts the phase to idle, the hold counts to 2 and 1, and the pins to
// write mode with the bus driven low; res.valid is low after reset.
module lcd_nibble_write_busy_poll (
	input  logic        clk,
	input  logic        arst_n,
	lnwb_in_if.sink     req,
	lnwb_out_if.source  res,
	lnwb_cfg_if.sink    cfg
);

	logic [lnwb_pkg::HOLD_W-1:0] write_hold_q;
	logic [lnwb_pkg::HOLD_W-1:0] poll_hold_q;
	logic                        push, pop;
	lnwb_pkg::cmd_t              push_cmd, head;
	lnwb_pkg::q_stat_t           q_stat;

	assign cfg.ready = 1'b1;

	// hold count registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_hold_q <= lnwb_pkg::WRITE_HOLD_RESET;
			poll_hold_q  <= lnwb_pkg::POLL_HOLD_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				lnwb_pkg::CFG_WRITE_HOLD: write_hold_q <= cfg.data;
				lnwb_pkg::CFG_POLL_HOLD:  poll_hold_q  <= cfg.data;
			endcase
		end
	end

	lnwb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.q_stat   (q_stat),
		.push     (push),
		.push_cmd (push_cmd)
	);

	lnwb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	lnwb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_stat     (q_stat),
		.write_hold (write_hold_q),
		.poll_hold  (poll_hold_q),
		.pop        (pop),
		.res        (res)
	);

endmodule
